@@ src/gspc_pkg.sv @@
// Shared types, constants and constant functions for the gas sensor ppm converter.
// Used by gspc_log2 and gas_sensor_ppm_converter_unit; depends on nothing else.
package gspc_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int RES_BITS        = 24;
	localparam int PPM_BITS        = 48;
	localparam int FRAC_BITS       = 16;
	localparam int LOG_ITERS       = 16;
	// leading-one stage, normalise stage, then one stage per fraction bit
	localparam int LOG_LAT         = LOG_ITERS + 2;
	localparam int EXP_ITERS       = 16;
	localparam int SLOPE_BITS      = 20;
	localparam int OFFSET_BITS     = 22;
	localparam int MANT_BITS       = 32;

	localparam logic [RES_BITS-1:0] RES_RESET = 24'd2560;
	// 1e6 ohm in Q20.8, used when the sensor voltage is too low to trust
	localparam int unsigned NUM_LOW = 256000000;
	localparam logic [MANT_BITS-1:0] ONE_Q30 = 32'h4000_0000;

	typedef enum logic [1:0] {
		GAS_CO,
		GAS_CH4,
		GAS_SMOKE,
		GAS_INVALID
	} gas_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_SEL,
		ST_SAT
	} status_t;

	// outcome known before the end of the datapath
	typedef enum logic [1:0] {
		EARLY_NONE,
		EARLY_BAD_SEL,
		EARLY_SAT,
		EARLY_ZERO
	} early_t;

	typedef enum logic [0:0] {
		REG_LOAD_RES,
		REG_CLEAN_AIR
	} cfg_reg_t;

	// slope a of the power law, Q16
	function automatic logic signed [SLOPE_BITS-1:0] slope_q16(input gas_t g);
		logic signed [SLOPE_BITS-1:0] s;
		case (g)
			GAS_CO:    s = -20'sd269156;
			GAS_CH4:   s = -20'sd148111;
			GAS_SMOKE: s = -20'sd78971;
			default:   s = '0;
		endcase
		return s;
	endfunction

	// b * log2(10), Q16
	function automatic logic signed [OFFSET_BITS-1:0] offset_q16(input gas_t g);
		logic signed [OFFSET_BITS-1:0] o;
		case (g)
			GAS_CO:    o = 22'sd1125975;
			GAS_CH4:   o = 22'sd735628;
			GAS_SMOKE: o = 22'sd643756;
			default:   o = '0;
		endcase
		return o;
	endfunction

	// floor square root, evaluated at elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem  = v;
		res  = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q1.30
	function automatic logic [MANT_BITS-1:0] exp2_coef(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 61);
		for (int j = 1; j < k; j++) begin
			c = isqrt64(c << 30);
		end
		return c[MANT_BITS-1:0];
	endfunction

endpackage

@@ src/gspc_log2.sv @@
// Pipelined base-2 logarithm, Q16 result, by repeated squaring of the mantissa.
// Depends on gspc_pkg for LOG_ITERS and FRAC_BITS.
module gspc_log2 import gspc_pkg::*; #(
	parameter int XW = SAMPLE_BITS_DEF + 6 + RES_BITS,
	localparam int PBW = $clog2(XW)
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [XW-1:0]            x,
	output logic [PBW+FRAC_BITS-1:0] lg
);

	logic [XW-1:0]  x_s1;
	logic [PBW-1:0] p_s1;
	logic [30:0]    norm;
	logic [30:0]    y_s2;
	logic [PBW-1:0] p_s2;

	logic [30:0]          y_s    [LOG_ITERS];
	logic [FRAC_BITS-1:0] frac_s [LOG_ITERS];
	logic [PBW-1:0]       p_s    [LOG_ITERS];

	function automatic logic [PBW-1:0] top_bit(input logic [XW-1:0] v);
		logic [PBW-1:0] p;
		p = '0;
		for (int i = 0; i < XW; i++) begin
			if (v[i]) p = PBW'(i);
		end
		return p;
	endfunction

	// shift the mantissa into [2^30, 2^31)
	always_comb begin
		if (p_s1 >= PBW'(30)) begin
			norm = 31'(x_s1 >> (p_s1 - PBW'(30)));
		end else begin
			norm = 31'(x_s1) << (PBW'(30) - p_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			p_s1 <= top_bit(x);
			y_s2 <= norm;
			p_s2 <= p_s1;
		end
	end

	for (genvar k = 0; k < LOG_ITERS; k++) begin : g_iter
		logic [30:0]          y_in;
		logic [FRAC_BITS-1:0] f_in;
		logic [PBW-1:0]       p_in;
		logic [61:0]          sq;
		logic [31:0]          t;

		if (k == 0) begin : g_first
			assign y_in = y_s2;
			assign f_in = '0;
			assign p_in = p_s2;
		end else begin : g_next
			assign y_in = y_s[k-1];
			assign f_in = frac_s[k-1];
			assign p_in = p_s[k-1];
		end

		assign sq = 62'(y_in) * 62'(y_in);
		assign t  = sq[61:30];

		// square overflows past 2: emit a one and halve
		always_ff @(posedge clk) begin
			if (en) begin
				y_s[k]    <= t[31] ? t[31:1] : t[30:0];
				frac_s[k] <= {f_in[FRAC_BITS-2:0], t[31]};
				p_s[k]    <= p_in;
			end
		end
	end

	assign lg = {p_s[LOG_ITERS-1], frac_s[LOG_ITERS-1]};

endmodule

@@ src/gas_sensor_ppm_converter_unit.sv @@
// Top level of the gas sensor ppm converter: resistance ratio, log, power law, exp.
// Depends on gspc_pkg and gspc_log2.
//
// Converts one raw converter sample and a gas selector (CO, CH4, smoke) into a
// concentration in ppm, unsigned Q32.16, with a status of ok, unknown selector or
// saturated. The block is a fully pipelined datapath: it accepts one beat every
// cycle while in_stall is low. A result beat passes two stages for the resistance
// products, eighteen in each of the two logarithm units, three for the slope
// multiply and rounding, sixteen for the fractional power of two and one output
// register. A two-entry output stage (output register plus skid register) keeps
// input beats flowing after the consumer stalls until the skid register holds a
// beat; in_stall is taken from it alone. Load and clean-air resistances are written
// through the cfg port and must only change while no beat is in flight.
module gas_sensor_ppm_converter_unit import gspc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [0:0]             cfg_index,
	input  logic [RES_BITS-1:0]    cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] raw_sample,
	input  logic [1:0]             func,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PPM_BITS-1:0]    ppm_value,
	output logic [1:0]             status
);

	localparam int FS   = (1 << SAMPLE_BITS) - 1;
	localparam int RW   = SAMPLE_BITS + 9;
	localparam int AW   = SAMPLE_BITS + 6;
	localparam int XW   = AW + RES_BITS;
	localparam int PBW  = $clog2(XW);
	localparam int LW   = PBW + FRAC_BITS;
	localparam int LGW  = LW + 1;
	localparam int PW   = LGW + SLOPE_BITS;
	localparam int EW   = PW - FRAC_BITS + 1;
	localparam int IPW  = EW - FRAC_BITS;
	localparam int EXTW = PPM_BITS + 1;

	localparam logic signed [IPW-1:0] IP_LIMIT = IPW'(32);
	localparam logic signed [IPW-1:0] IP_BIAS  = IPW'(14);
	localparam logic signed [IPW-1:0] RS_MAX   = IPW'(31);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [RES_BITS-1:0] load_resistance_q;
	logic [RES_BITS-1:0] clean_air_resistance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_resistance_q      <= RES_RESET;
			clean_air_resistance_q <= RES_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOAD_RES:  load_resistance_q      <= cfg_data;
				REG_CLEAN_AIR: clean_air_resistance_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control: the whole pipe advances while the skid register is
	// empty, so in_stall comes straight from a flop.
	// ---------------------------------------------------------------
	logic skid_valid_q;
	logic out_valid_q;
	logic adv;
	logic take;

	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign take     = out_valid_q && !out_stall;

	// ---------------------------------------------------------------
	// Stage 1: low-voltage test and the two sample-side factors
	//   a = 50*FS - 33*r  ~ (5 - V), b = 33*r ~ V
	// ---------------------------------------------------------------
	logic [RW-1:0] r330;
	logic          low;
	logic [AW-1:0] a_c;
	logic [AW-1:0] b_c;
	early_t        early_c;

	assign r330 = RW'(raw_sample) * RW'(330);
	assign low  = r330 <= RW'(FS);
	assign b_c  = AW'(raw_sample) * AW'(33);
	assign a_c  = AW'(50 * FS) - b_c;

	always_comb begin
		if (gas_t'(func) == GAS_INVALID) begin
			early_c = EARLY_BAD_SEL;
		end else if (!low && load_resistance_q == '0) begin
			// zero ratio: log runs to minus infinity, result saturates
			early_c = EARLY_SAT;
		end else if (clean_air_resistance_q == '0) begin
			// unbounded ratio: result underflows to zero
			early_c = EARLY_ZERO;
		end else begin
			early_c = EARLY_NONE;
		end
	end

	logic          v_s1;
	logic          low_s1;
	logic [AW-1:0] a_s1;
	logic [AW-1:0] b_s1;
	gas_t          sel_s1;
	early_t        early_s1;

	// ---------------------------------------------------------------
	// Stage 2: numerator and denominator of Rs/Ro
	// ---------------------------------------------------------------
	logic          v_s2;
	logic [XW-1:0] num_s2;
	logic [XW-1:0] den_s2;
	gas_t          sel_s2;
	early_t        early_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			low_s1   <= low;
			a_s1     <= a_c;
			b_s1     <= b_c;
			sel_s1   <= gas_t'(func);
			early_s1 <= early_c;

			num_s2   <= low_s1 ? XW'(NUM_LOW) : XW'(a_s1) * XW'(load_resistance_q);
			den_s2   <= low_s1 ? XW'(clean_air_resistance_q)
			                   : XW'(b_s1) * XW'(clean_air_resistance_q);
			sel_s2   <= sel_s1;
			early_s2 <= early_s1;
		end
	end

	// ---------------------------------------------------------------
	// Logarithms of numerator and denominator, side data delayed alongside
	// ---------------------------------------------------------------
	logic [LW-1:0] lg_num;
	logic [LW-1:0] lg_den;

	gspc_log2 #(.XW(XW)) u_log_num (
		.clk (clk),
		.en  (adv),
		.x   (num_s2),
		.lg  (lg_num)
	);

	gspc_log2 #(.XW(XW)) u_log_den (
		.clk (clk),
		.en  (adv),
		.x   (den_s2),
		.lg  (lg_den)
	);

	logic   v_sl     [LOG_LAT];
	gas_t   sel_sl   [LOG_LAT];
	early_t early_sl [LOG_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOG_LAT; i++) v_sl[i] <= 1'b0;
		end else if (adv) begin
			v_sl[0] <= v_s2;
			for (int i = 1; i < LOG_LAT; i++) v_sl[i] <= v_sl[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_sl[0]   <= sel_s2;
			early_sl[0] <= early_s2;
			for (int i = 1; i < LOG_LAT; i++) begin
				sel_sl[i]   <= sel_sl[i-1];
				early_sl[i] <= early_sl[i-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Difference of logs, slope multiply, round and add offset
	// ---------------------------------------------------------------
	logic                          v_sd;
	logic signed [LGW-1:0]         lgd_sd;
	logic signed [SLOPE_BITS-1:0]  slope_sd;
	logic signed [OFFSET_BITS-1:0] offset_sd;
	early_t                        early_sd;

	logic                          v_sm;
	logic signed [PW-1:0]          prod_sm;
	logic signed [OFFSET_BITS-1:0] offset_sm;
	early_t                        early_sm;

	logic signed [PW-1:0]          rnd;
	logic signed [EW-1:0]          e_c;
	logic signed [IPW-1:0]         ip_c;

	logic                          v_se;
	logic signed [IPW-1:0]         ip_se;
	logic [FRAC_BITS-1:0]          fp_se;
	early_t                        early_se;

	// half-up rounding from Q32 to Q16, then split into floor and fraction
	assign rnd  = prod_sm + PW'(32768);
	assign e_c  = EW'(rnd >>> FRAC_BITS) + EW'(offset_sm);
	assign ip_c = e_c[EW-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
			v_sm <= 1'b0;
			v_se <= 1'b0;
		end else if (adv) begin
			v_sd <= v_sl[LOG_LAT-1];
			v_sm <= v_sd;
			v_se <= v_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lgd_sd    <= $signed({1'b0, lg_num}) - $signed({1'b0, lg_den});
			slope_sd  <= slope_q16(sel_sl[LOG_LAT-1]);
			offset_sd <= offset_q16(sel_sl[LOG_LAT-1]);
			early_sd  <= early_sl[LOG_LAT-1];

			prod_sm   <= PW'(slope_sd) * PW'(lgd_sd);
			offset_sm <= offset_sd;
			early_sm  <= early_sd;

			ip_se     <= ip_c;
			fp_se     <= e_c[FRAC_BITS-1:0];
			// exponent beyond Q32 range saturates
			early_se  <= (early_sm == EARLY_NONE && ip_c >= IP_LIMIT) ? EARLY_SAT : early_sm;
		end
	end

	// ---------------------------------------------------------------
	// 2^fraction: one conditional multiply per fraction bit, MSB first
	// ---------------------------------------------------------------
	logic                 v_sx     [EXP_ITERS];
	logic [MANT_BITS-1:0] m_sx     [EXP_ITERS];
	logic [FRAC_BITS-1:0] fp_sx    [EXP_ITERS];
	logic signed [IPW-1:0] ip_sx   [EXP_ITERS];
	early_t               early_sx [EXP_ITERS];

	for (genvar k = 0; k < EXP_ITERS; k++) begin : g_exp
		localparam logic [MANT_BITS-1:0] COEF = exp2_coef(k + 1);

		logic                  v_in;
		logic [MANT_BITS-1:0]  m_in;
		logic [FRAC_BITS-1:0]  fp_in;
		logic signed [IPW-1:0] ip_in;
		early_t                early_in;
		logic [63:0]           mul;

		if (k == 0) begin : g_first
			assign v_in     = v_se;
			assign m_in     = ONE_Q30;
			assign fp_in    = fp_se;
			assign ip_in    = ip_se;
			assign early_in = early_se;
		end else begin : g_next
			assign v_in     = v_sx[k-1];
			assign m_in     = m_sx[k-1];
			assign fp_in    = fp_sx[k-1];
			assign ip_in    = ip_sx[k-1];
			assign early_in = early_sx[k-1];
		end

		assign mul = 64'(m_in) * 64'(COEF) + (64'd1 << 29);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sx[k] <= 1'b0;
			end else if (adv) begin
				v_sx[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				m_sx[k]     <= fp_in[FRAC_BITS-1-k] ? mul[61:30] : m_in;
				fp_sx[k]    <= fp_in;
				ip_sx[k]    <= ip_in;
				early_sx[k] <= early_in;
			end
		end
	end

	// ---------------------------------------------------------------
	// Scale by 2^(I-14), saturate, pick the final beat
	// ---------------------------------------------------------------
	logic signed [IPW-1:0] ls_c;
	logic signed [IPW-1:0] rs_c;
	logic [EXTW-1:0]       ext_c;
	logic [PPM_BITS-1:0]   new_ppm;
	status_t               new_status;

	assign ls_c = ip_sx[EXP_ITERS-1] - IP_BIAS;
	assign rs_c = IP_BIAS - ip_sx[EXP_ITERS-1];

	always_comb begin
		if (!ls_c[IPW-1]) begin
			ext_c = EXTW'(m_sx[EXP_ITERS-1]) << ls_c[4:0];
		end else if (rs_c > RS_MAX) begin
			// shifted out entirely
			ext_c = '0;
		end else begin
			ext_c = EXTW'(m_sx[EXP_ITERS-1] >> rs_c[4:0]);
		end
	end

	always_comb begin
		case (early_sx[EXP_ITERS-1])
			EARLY_BAD_SEL: begin
				new_ppm    = '0;
				new_status = ST_BAD_SEL;
			end
			EARLY_SAT: begin
				new_ppm    = '1;
				new_status = ST_SAT;
			end
			EARLY_ZERO: begin
				new_ppm    = '0;
				new_status = ST_OK;
			end
			default: begin
				if (ext_c[EXTW-1]) begin
					new_ppm    = '1;
					new_status = ST_SAT;
				end else begin
					new_ppm    = ext_c[PPM_BITS-1:0];
					new_status = ST_OK;
				end
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Output register and skid register
	// ---------------------------------------------------------------
	logic [PPM_BITS-1:0] ppm_q;
	status_t             status_q;
	logic [PPM_BITS-1:0] skid_ppm_q;
	status_t             skid_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (adv) begin
			if (!out_valid_q || take) begin
				out_valid_q <= v_sx[EXP_ITERS-1];
			end else begin
				// output held: park the arriving beat
				skid_valid_q <= v_sx[EXP_ITERS-1];
			end
		end else if (take) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!out_valid_q || take) begin
				ppm_q    <= new_ppm;
				status_q <= new_status;
			end else begin
				skid_ppm_q    <= new_ppm;
				skid_status_q <= new_status;
			end
		end else if (take) begin
			ppm_q    <= skid_ppm_q;
			status_q <= skid_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ppm_value = ppm_q;
	assign status    = status_q;

endmodule

@@ bench/gas_sensor_ppm_converter_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for gas_sensor_ppm_converter_unit: directed and random samples.
// Depends on gspc_pkg and the converter RTL; carries its own fixed-point ppm predictor.
module gas_sensor_ppm_converter_unit_test;
	import gspc_pkg::*;

	localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
	localparam int RESET_CYCLES = 12;
	// pipeline depth plus the two-entry output stage
	localparam int LATENCY      = 42;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam longint unsigned PPM_FULL = (64'd1 << PPM_BITS) - 1;
	localparam logic [RES_BITS-1:0] RES_MAX = '1;

	typedef struct packed {
		logic [PPM_BITS-1:0] ppm;
		status_t             st;
	} reading_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [0:0]             cfg_index = REG_LOAD_RES;
	logic [RES_BITS-1:0]    cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [SAMPLE_W-1:0]    raw_sample = '0;
	logic [1:0]             func = GAS_CO;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [PPM_BITS-1:0]    ppm_value;
	logic [1:0]             status;

	// local copies of the resistance registers, as last written
	logic [RES_BITS-1:0] load_res = RES_RESET;
	logic [RES_BITS-1:0] clean_air_res = RES_RESET;

	// 2^(2^-k) in Q1.30 for k = 1..16
	longint unsigned exp2_steps [1:16];

	reading_t expected_readings [$];
	int       mismatches = 0;
	int       cycle_count = 0;

	// receiver hold-off requests, served by the stall process
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;

	gas_sensor_ppm_converter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.raw_sample (raw_sample),
		.func       (func),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ppm_value  (ppm_value),
		.status     (status)
	);

	always #10 clk = ~clk;

	// Watchdog: give up well beyond the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// floor square root, one result bit at a time from the top
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res;
		longint unsigned cand;
		res = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if (cand * cand <= v)
				res = cand;
		end
		return res;
	endfunction

	function automatic void fill_exp2_steps();
		longint unsigned c;
		c = root_floor(64'd1 << 61);
		for (int k = 1; k <= 16; k++) begin
			exp2_steps[k] = c;
			c = root_floor(c << 30);
		end
	endfunction

	// log2 of x > 0 in Q16: leading-one index plus 16 squaring steps on the mantissa
	function automatic longint log2_fix(input longint unsigned x);
		int              p;
		longint unsigned y;
		longint          frac;
		p = 63;
		frac = 0;
		while (x[p] == 1'b0 && p > 0)
			p--;
		if (p >= 30)
			y = x >> (p - 30);
		else
			y = x << (30 - p);
		for (int k = 0; k < FRAC_BITS; k++) begin
			y = (y * y) >> 30;
			frac = frac << 1;
			if (y >= (64'd1 << 31)) begin
				frac = frac | 1;
				y = y >> 1;
			end
		end
		return longint'(p) * 65536 + frac;
	endfunction

	// 2^(f/65536) in Q1.30
	function automatic longint unsigned exp2_fix(input logic [15:0] f);
		longint unsigned m;
		m = 64'd1 << 30;
		for (int k = 1; k <= 16; k++) begin
			if (f[16-k])
				m = (m * exp2_steps[k] + (64'd1 << 29)) >> 30;
		end
		return m;
	endfunction

	// Expected ppm reading of one sample under the current resistances.
	function automatic reading_t convert_sample(input logic [SAMPLE_W-1:0] raw, input gas_t gas);
		longint unsigned fs;
		longint unsigned r;
		longint unsigned num;
		longint unsigned den;
		longint unsigned m;
		longint unsigned ppm;
		longint          lg;
		longint          e;
		longint          ip;
		longint          fp;
		longint          slope;
		longint          offset;
		reading_t        res;
		fs = (64'd1 << SAMPLE_W) - 1;
		r = raw;
		res.ppm = '0;
		res.st = ST_OK;
		if (gas == GAS_INVALID) begin
			res.st = ST_BAD_SEL;
			return res;
		end
		// below 10 mV the sensor resistance is pinned at 1e6
		if (r * 330 <= fs) begin
			num = 256000000;
			den = clean_air_res;
		end else begin
			num = (50 * fs - 33 * r) * load_res;
			den = 33 * r * clean_air_res;
		end
		if (num == 0) begin
			res.ppm = PPM_FULL[PPM_BITS-1:0];
			res.st = ST_SAT;
			return res;
		end
		if (den == 0)
			return res;
		case (gas)
			GAS_CO: begin
				slope = -269156;
				offset = 1125975;
			end
			GAS_CH4: begin
				slope = -148111;
				offset = 735628;
			end
			default: begin
				slope = -78971;
				offset = 643756;
			end
		endcase
		lg = log2_fix(num) - log2_fix(den);
		e = ((slope * lg + 32768) >>> 16) + offset;
		ip = e >>> 16;
		fp = e - ip * 65536;
		if (ip >= 32) begin
			res.ppm = PPM_FULL[PPM_BITS-1:0];
			res.st = ST_SAT;
			return res;
		end
		m = exp2_fix(fp[15:0]);
		if (ip >= 14)
			ppm = m << (ip - 14);
		else if (14 - ip >= 63)
			ppm = 0;
		else
			ppm = m >> (14 - ip);
		if (ppm > PPM_FULL) begin
			res.ppm = PPM_FULL[PPM_BITS-1:0];
			res.st = ST_SAT;
		end else begin
			res.ppm = ppm[PPM_BITS-1:0];
		end
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Receiver and checker
	// ---------------------------------------------------------------------

	// Stall on a pattern that changes mode every so often; serve long hold-offs on request.
	always @(posedge clk) begin
		stall_phase = (stall_phase + 1) % 16;
		if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 7) == 0);
				2:       out_stall <= 1'($urandom_range(0, 1));
				default: out_stall <= (stall_phase < 5);
			endcase
		end
	end

	// Sample mid-cycle: a beat seen here is taken at the next rising edge.
	always @(negedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: ppm %h status %0d", ppm_value, status);
			end else begin
				want = expected_readings.pop_front();
				if (ppm_value !== want.ppm || status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: ppm exp %h got %h, status exp %0d got %0d",
							want.ppm, ppm_value, want.st, status);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sender and configuration
	// ---------------------------------------------------------------------

	// Offer one sample and hold it until taken; returns at the accepting edge, valid still high.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] raw, input gas_t gas);
		bit taken;
		in_valid <= 1'b1;
		raw_sample <= raw;
		func <= gas;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		expected_readings.push_back(convert_sample(raw, gas));
	endtask

	// Drop valid and wait until every expected reading has come back.
	task automatic settle_pipeline();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [RES_BITS-1:0] value);
		settle_pipeline();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_LOAD_RES)
			load_res = value;
		else
			clean_air_res = value;
	endtask

	function automatic logic [SAMPLE_W-1:0] random_raw();
		case ($urandom_range(0, 9))
			0, 1:    return SAMPLE_W'($urandom_range(0, 20));
			2:       return SAMPLE_W'($urandom_range(4075, 4095));
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic gas_t random_gas();
		if ($urandom_range(0, 15) == 0)
			return GAS_INVALID;
		return gas_t'(2'($urandom_range(0, 2)));
	endfunction

	// Stream random samples, in bursts with gaps between them when asked.
	task automatic stream_samples(input int count, input bit with_gaps);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 20);
		for (int i = 0; i < count; i++) begin
			offer_sample(random_raw(), random_gas());
			if (with_gaps) begin
				burst_left--;
				if (burst_left == 0) begin
					gap = $urandom_range(0, 8);
					if (gap > 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst_left = $urandom_range(1, 20);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset resistances: voltage threshold edges, sample extremes, every selector.
	task automatic test_reset_settings();
		offer_sample(0, GAS_CO);
		offer_sample(12, GAS_CO);
		offer_sample(13, GAS_CH4);
		offer_sample(4095, GAS_CO);
		offer_sample(4095, GAS_CH4);
		offer_sample(4095, GAS_SMOKE);
		offer_sample(2048, GAS_SMOKE);
		offer_sample(2048, GAS_INVALID);
		offer_sample(4095, GAS_INVALID);
		offer_sample(0, GAS_INVALID);
	endtask

	// Zero load resistance saturates save at low voltage; zero clean-air resistance reads zero.
	task automatic test_zero_resistances();
		write_reg(REG_LOAD_RES, '0);
		offer_sample(100, GAS_CO);
		offer_sample(5, GAS_SMOKE);
		write_reg(REG_LOAD_RES, RES_RESET);
		write_reg(REG_CLEAN_AIR, '0);
		offer_sample(100, GAS_CH4);
		offer_sample(3, GAS_CO);
	endtask

	// Tiny ratio drives the exponent past the range; huge ratio underflows to zero.
	task automatic test_extreme_ratios();
		write_reg(REG_LOAD_RES, 24'd1);
		write_reg(REG_CLEAN_AIR, RES_MAX);
		offer_sample(4095, GAS_CO);
		offer_sample(4095, GAS_SMOKE);
		write_reg(REG_LOAD_RES, RES_MAX);
		write_reg(REG_CLEAN_AIR, 24'd1);
		offer_sample(0, GAS_CO);
		offer_sample(13, GAS_SMOKE);
		offer_sample(4095, GAS_CH4);
	endtask

	// Several resistance settings, extremes among them, random samples under each.
	task automatic test_random_sweep();
		logic [RES_BITS-1:0] rl;
		logic [RES_BITS-1:0] ro;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					rl = RES_BITS'($urandom_range(1, 24'hFFFFFF));
					ro = RES_BITS'($urandom_range(1, 24'hFFFFFF));
				end
				1: begin
					rl = 24'd1;
					ro = RES_MAX;
				end
				2: begin
					rl = RES_MAX;
					ro = 24'd1;
				end
				3: begin
					rl = RES_BITS'($urandom_range(1, 4096));
					ro = RES_BITS'($urandom_range(1, 24'hFFFFFF));
				end
				4: begin
					rl = RES_RESET;
					ro = RES_BITS'($urandom_range(1, 65536));
				end
				default: begin
					rl = RES_MAX;
					ro = RES_MAX;
				end
			endcase
			write_reg(REG_LOAD_RES, rl);
			write_reg(REG_CLEAN_AIR, ro);
			stream_samples(165, 1'b1);
		end
	endtask

	// Hold the receiver off for a long stretch while samples keep coming, filling the pipe.
	task automatic test_back_pressure();
		write_reg(REG_LOAD_RES, RES_BITS'($urandom_range(1, 24'hFFFFFF)));
		write_reg(REG_CLEAN_AIR, RES_RESET);
		hold_requests++;
		stream_samples(120, 1'b0);
	endtask

	initial begin
		fill_exp2_steps();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_zero_resistances();
		test_extreme_ratios();
		test_random_sweep();
		test_back_pressure();
		settle_pipeline();
		// let any stray beat surface
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
